@@ hw/rtl/tufn_pkg.sv @@
`default_nettype none
package tufn_pkg;

  localparam int CW      = 16;
  localparam int EW      = CW + 1;
  localparam int MW      = 2 * CW + 2;
  localparam int HW      = $clog2(MW + 1);
  localparam int NMW     = 30;
  localparam int SQW     = 2 * NMW;
  localparam int SW      = 2 * NMW + 2;
  localparam int RTW     = SW / 2;
  localparam int RMW     = RTW + 3;
  localparam int QW      = 15;
  localparam int NW      = NMW + QW + 1;
  localparam int OW      = 16;
  localparam int ONE_Q14 = 16384;
  localparam int SQ_ST   = RTW;
  localparam int DIV_ST  = QW;
  localparam int LAT     = 7 + SQ_ST + DIV_ST + 1;

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] mag;
  } cross_t;

  typedef struct packed {
    logic       deg;
    logic [2:0] neg;
  } side_t;

endpackage
`default_nettype wire

@@ hw/rtl/tufn_cross_lane.sv @@
`default_nettype none
module tufn_cross_lane (
  input  wire logic                          clk,
  input  wire logic signed [tufn_pkg::EW-1:0] p,
  input  wire logic signed [tufn_pkg::EW-1:0] q,
  input  wire logic signed [tufn_pkg::EW-1:0] s,
  input  wire logic signed [tufn_pkg::EW-1:0] t,
  output tufn_pkg::cross_t                   res
);

  logic signed [2*tufn_pkg::EW-1:0] pq_r;
  logic signed [2*tufn_pkg::EW-1:0] st_r;
  logic signed [tufn_pkg::MW:0]     diff;
  tufn_pkg::cross_t                 res_r;
  tufn_pkg::cross_t                 res_nxt;

  always_ff @(posedge clk) begin
    pq_r  <= p * q;
    st_r  <= s * t;
    res_r <= res_nxt;
  end

  always_comb begin
    diff        = {pq_r[2*tufn_pkg::EW-1], pq_r} - {st_r[2*tufn_pkg::EW-1], st_r};
    res_nxt.neg = diff[tufn_pkg::MW];
    res_nxt.mag = diff[tufn_pkg::MW] ? tufn_pkg::MW'(-diff) : diff[tufn_pkg::MW-1:0];
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ hw/rtl/tufn_isqrt.sv @@
`default_nettype none
module tufn_isqrt (
  input  wire logic                    clk,
  input  wire logic [tufn_pkg::SW-1:0] s,
  output logic      [tufn_pkg::RTW-1:0] root
);

  logic [tufn_pkg::SW-1:0]  s_r    [tufn_pkg::SQ_ST-1];
  logic [tufn_pkg::RMW-1:0] rem_r  [tufn_pkg::SQ_ST-1];
  logic [tufn_pkg::RTW-1:0] root_r [tufn_pkg::SQ_ST];

  for (genvar k = 0; k < tufn_pkg::SQ_ST; k++) begin : g_stage
    logic [tufn_pkg::SW-1:0]  si;
    logic [tufn_pkg::RMW-1:0] remi;
    logic [tufn_pkg::RTW-1:0] rooti;
    logic [tufn_pkg::RMW-1:0] rem_t;
    logic [tufn_pkg::RMW-1:0] trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign si    = s;
      assign remi  = '0;
      assign rooti = '0;
    end else begin : g_next
      assign si    = s_r[k-1];
      assign remi  = rem_r[k-1];
      assign rooti = root_r[k-1];
    end

    always_comb begin
      rem_t = {remi[tufn_pkg::RMW-3:0], si[tufn_pkg::SW-1:tufn_pkg::SW-2]};
      trial = {{(tufn_pkg::RMW-tufn_pkg::RTW-2){1'b0}}, rooti, 2'b01};
      ge    = rem_t >= trial;
    end

    always_ff @(posedge clk) begin
      root_r[k] <= {rooti[tufn_pkg::RTW-2:0], ge};
    end

    if (k < tufn_pkg::SQ_ST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        s_r[k]   <= {si[tufn_pkg::SW-3:0], 2'b00};
        rem_r[k] <= ge ? rem_t - trial : rem_t;
      end
    end
  end

  assign root = root_r[tufn_pkg::SQ_ST-1];

endmodule
`default_nettype wire

@@ hw/rtl/tufn_div_lane.sv @@
`default_nettype none
module tufn_div_lane (
  input  wire logic                     clk,
  input  wire logic [tufn_pkg::NMW-1:0] m,
  input  wire logic [tufn_pkg::RTW-1:0] len,
  output logic      [tufn_pkg::QW-1:0]  q
);

  localparam int DW = tufn_pkg::RTW + 1;

  logic [tufn_pkg::NW-1:0] num;
  logic [DW-1:0]           rem_r [tufn_pkg::DIV_ST-1];
  logic [DW-1:0]           d_r   [tufn_pkg::DIV_ST-1];
  logic [tufn_pkg::QW-1:0] low_r [tufn_pkg::DIV_ST-1];
  logic [tufn_pkg::QW-1:0] q_r   [tufn_pkg::DIV_ST];

  assign num = {1'b0, m, {tufn_pkg::QW{1'b0}}} + tufn_pkg::NW'(len);

  for (genvar k = 0; k < tufn_pkg::DIV_ST; k++) begin : g_stage
    logic [DW-1:0]           remi;
    logic [DW-1:0]           di;
    logic [tufn_pkg::QW-1:0] lowi;
    logic [tufn_pkg::QW-1:0] qi;
    logic [DW:0]             rem_t;
    logic                    ge;

    if (k == 0) begin : g_first
      assign remi = {1'b0, num[tufn_pkg::NW-1:tufn_pkg::QW]};
      assign di   = {len, 1'b0};
      assign lowi = num[tufn_pkg::QW-1:0];
      assign qi   = '0;
    end else begin : g_next
      assign remi = rem_r[k-1];
      assign di   = d_r[k-1];
      assign lowi = low_r[k-1];
      assign qi   = q_r[k-1];
    end

    always_comb begin
      rem_t = {remi, lowi[tufn_pkg::QW-1]};
      ge    = rem_t >= {1'b0, di};
    end

    always_ff @(posedge clk) begin
      q_r[k] <= {qi[tufn_pkg::QW-2:0], ge};
    end

    if (k < tufn_pkg::DIV_ST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? DW'(rem_t - {1'b0, di}) : DW'(rem_t);
        d_r[k]   <= di;
        low_r[k] <= {lowi[tufn_pkg::QW-2:0], 1'b0};
      end
    end
  end

  assign q = q_r[tufn_pkg::DIV_ST-1];

endmodule
`default_nettype wire

@@ hw/rtl/triangle_unit_face_normal_core.sv @@
`default_nettype none
// Unit face normal of a triangle, fully pipelined: a new triangle is taken on
// every clock edge where start is high, since busy is always low. Each result
// appears on the out_ ports for exactly one cycle with out_valid high; the
// receiver cannot stall, so it must take every beat.
// The pipeline includes the 31-stage square root and the 15-stage dividers.
module triangle_unit_face_normal_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [tufn_pkg::CW-1:0] in_ax,
  input  wire logic signed [tufn_pkg::CW-1:0] in_ay,
  input  wire logic signed [tufn_pkg::CW-1:0] in_az,
  input  wire logic signed [tufn_pkg::CW-1:0] in_bx,
  input  wire logic signed [tufn_pkg::CW-1:0] in_by,
  input  wire logic signed [tufn_pkg::CW-1:0] in_bz,
  input  wire logic signed [tufn_pkg::CW-1:0] in_cx,
  input  wire logic signed [tufn_pkg::CW-1:0] in_cy,
  input  wire logic signed [tufn_pkg::CW-1:0] in_cz,
  output logic                               out_valid,
  output logic signed [tufn_pkg::OW-1:0]     out_nx,
  output logic signed [tufn_pkg::OW-1:0]     out_ny,
  output logic signed [tufn_pkg::OW-1:0]     out_nz,
  output logic                               out_degenerate
);

  localparam int EW  = tufn_pkg::EW;
  localparam int MW  = tufn_pkg::MW;
  localparam int NMW = tufn_pkg::NMW;
  localparam int DLY = tufn_pkg::SQ_ST + tufn_pkg::DIV_ST;

  logic [tufn_pkg::LAT-1:0] vld_r;

  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;

  tufn_pkg::cross_t r0, r1, r2;

  logic [MW-1:0]          any_mag;
  logic [tufn_pkg::HW-1:0] h_nxt;
  logic [tufn_pkg::HW-1:0] sh_r;
  logic [2:0][MW-1:0]     mag_r;
  tufn_pkg::side_t        side_h_r, side_m_r, side_sq_r, side_sum_r;
  tufn_pkg::side_t        side_dl_r [DLY];

  logic [2:0][NMW-1:0]            m_r, m_sq_r, m_sum_r;
  logic [NMW-1:0]                 m_dl_r [tufn_pkg::SQ_ST][3];
  logic [2:0][tufn_pkg::SQW-1:0]  sq_r;
  logic [tufn_pkg::SW-1:0]        sum_r;
  logic [tufn_pkg::RTW-1:0]       root;
  logic [2:0][tufn_pkg::QW-1:0]   q;
  logic [2:0][tufn_pkg::OW-1:0]   n_nxt;
  logic [2:0][tufn_pkg::OW-1:0]   n_r;
  logic                           deg_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[tufn_pkg::LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    e1x_r <= EW'(in_bx) - EW'(in_ax);
    e1y_r <= EW'(in_by) - EW'(in_ay);
    e1z_r <= EW'(in_bz) - EW'(in_az);
    e2x_r <= EW'(in_cx) - EW'(in_ax);
    e2y_r <= EW'(in_cy) - EW'(in_ay);
    e2z_r <= EW'(in_cz) - EW'(in_az);
  end

  tufn_cross_lane u_lane_x (.clk(clk), .p(e1y_r), .q(e2z_r), .s(e1z_r), .t(e2y_r), .res(r0));
  tufn_cross_lane u_lane_y (.clk(clk), .p(e1z_r), .q(e2x_r), .s(e1x_r), .t(e2z_r), .res(r1));
  tufn_cross_lane u_lane_z (.clk(clk), .p(e1x_r), .q(e2y_r), .s(e1y_r), .t(e2x_r), .res(r2));

  always_comb begin
    any_mag = r0.mag | r1.mag | r2.mag;
    h_nxt   = '0;
    for (int i = 0; i < MW; i++) begin
      if (any_mag[i]) begin
        h_nxt = tufn_pkg::HW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r         <= h_nxt;
    mag_r        <= {r2.mag, r1.mag, r0.mag};
    side_h_r.deg <= (any_mag == '0);
    side_h_r.neg <= {r2.neg, r1.neg, r0.neg};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m_r[i]  <= NMW'({mag_r[i], {NMW{1'b0}}} >> sh_r);
      sq_r[i] <= m_r[i] * m_r[i];
    end
    side_m_r   <= side_h_r;
    side_sq_r  <= side_m_r;
    m_sq_r     <= m_r;
    sum_r      <= tufn_pkg::SW'(sq_r[0]) + tufn_pkg::SW'(sq_r[1]) + tufn_pkg::SW'(sq_r[2]);
    side_sum_r <= side_sq_r;
    m_sum_r    <= m_sq_r;
  end

  tufn_isqrt u_isqrt (.clk(clk), .s(sum_r), .root(root));

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      m_dl_r[0][j] <= m_sum_r[j];
    end
    for (int i = 1; i < tufn_pkg::SQ_ST; i++) begin
      m_dl_r[i] <= m_dl_r[i-1];
    end
    side_dl_r[0] <= side_sum_r;
    for (int i = 1; i < DLY; i++) begin
      side_dl_r[i] <= side_dl_r[i-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    logic [tufn_pkg::QW-1:0] qs;

    tufn_div_lane u_div (
      .clk(clk), .m(m_dl_r[tufn_pkg::SQ_ST-1][j]), .len(root), .q(q[j])
    );

    always_comb begin
      qs = (q[j] > tufn_pkg::QW'(tufn_pkg::ONE_Q14)) ? tufn_pkg::QW'(tufn_pkg::ONE_Q14) : q[j];
      if (side_dl_r[DLY-1].deg) begin
        n_nxt[j] = '0;
      end else if (side_dl_r[DLY-1].neg[j]) begin
        n_nxt[j] = tufn_pkg::OW'(-tufn_pkg::OW'(qs));
      end else begin
        n_nxt[j] = tufn_pkg::OW'(qs);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    deg_r <= side_dl_r[DLY-1].deg;
  end

  assign out_valid      = vld_r[tufn_pkg::LAT-1];
  assign out_nx         = n_r[0];
  assign out_ny         = n_r[1];
  assign out_nz         = n_r[2];
  assign out_degenerate = deg_r;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
    else $error("degenerate beat with nonzero normal");

  a_nx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_nx) <= tufn_pkg::ONE_Q14 && $signed(out_nx) >= -tufn_pkg::ONE_Q14)
    else $error("normal x out of range");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(tufn_pkg::LAT) out_valid)
    else $error("result beat missing after input beat");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, tufn_pkg::LAT))
    else $error("result beat without input beat");
`endif

endmodule
`default_nettype wire

@@ tb/tb_triangle_unit_face_normal_checker.sv @@
module tb_triangle_unit_face_normal_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic                               busy,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_ax,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_ay,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_az,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_bx,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_by,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_bz,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_cx,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_cy,
  input  wire logic signed [tufn_pkg::CW-1:0]     in_cz,
  input  wire logic                               out_valid,
  input  wire logic signed [tufn_pkg::OW-1:0]     out_nx,
  input  wire logic signed [tufn_pkg::OW-1:0]     out_ny,
  input  wire logic signed [tufn_pkg::OW-1:0]     out_nz,
  input  wire logic                               out_degenerate,
  output int                                      fail_count,
  output int                                      normals_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        deg;
  } normal_t;

  normal_t normal_q[$];

  function automatic logic [15:0] unit_component(longint signed r, int h,
                                                 logic [127:0] len);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (r < 0) ? -r : r;
    if (h < 29) mag = mag << (29 - h);
    else mag = mag >> (h - 29);
    q = ((mag << 15) + len) / (len << 1);
    if (q > 16384) q = 16384;
    return (r < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic normal_t face_normal(logic signed [15:0] ax, ay, az, bx, by, bz,
                                          cx, cy, cz);
    longint signed e1x, e1y, e1z, e2x, e2y, e2z, rx, ry, rz;
    logic [127:0] m0, m1, m2, orall, s, len, bitv, rem;
    int h;
    normal_t n;
    e1x = bx - ax; e1y = by - ay; e1z = bz - az;
    e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
    rx = e1y * e2z - e1z * e2y;
    ry = e1z * e2x - e1x * e2z;
    rz = e1x * e2y - e1y * e2x;
    n = '0;
    if (rx == 0 && ry == 0 && rz == 0) begin
      n.deg = 1'b1;
      return n;
    end
    m0 = (rx < 0) ? -rx : rx;
    m1 = (ry < 0) ? -ry : ry;
    m2 = (rz < 0) ? -rz : rz;
    orall = m0 | m1 | m2;
    h = 127;
    while (!orall[h]) h--;
    if (h < 29) begin
      m0 = m0 << (29 - h); m1 = m1 << (29 - h); m2 = m2 << (29 - h);
    end else begin
      m0 = m0 >> (h - 29); m1 = m1 >> (h - 29); m2 = m2 >> (h - 29);
    end
    s = m0 * m0 + m1 * m1 + m2 * m2;
    len = 0;
    rem = s;
    bitv = 128'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem = rem - (len + bitv);
        len = (len >> 1) + bitv;
      end else begin
        len = len >> 1;
      end
      bitv = bitv >> 2;
    end
    n.nx = unit_component(rx, h, len);
    n.ny = unit_component(ry, h, len);
    n.nz = unit_component(rz, h, len);
    return n;
  endfunction

  assign normals_pending = normal_q.size();

  always @(posedge clk) begin
    normal_t exp_n;
    normal_t got;
    if (rst_n) begin
      if (start && !busy) begin
        normal_q.push_back(face_normal(in_ax, in_ay, in_az, in_bx, in_by, in_bz,
                                       in_cx, in_cy, in_cz));
      end
      if (out_valid) begin
        got = '{out_nx, out_ny, out_nz, out_degenerate};
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected normal beat %h", $time, got);
          fail_count++;
        end else begin
          exp_n = normal_q.pop_front();
          if (got.nx !== exp_n.nx) begin
            $display("%0t: nx expected %0d got %0d", $time, $signed(exp_n.nx),
                     $signed(got.nx));
            fail_count++;
          end
          if (got.ny !== exp_n.ny) begin
            $display("%0t: ny expected %0d got %0d", $time, $signed(exp_n.ny),
                     $signed(got.ny));
            fail_count++;
          end
          if (got.nz !== exp_n.nz) begin
            $display("%0t: nz expected %0d got %0d", $time, $signed(exp_n.nz),
                     $signed(got.nz));
            fail_count++;
          end
          if (got.deg !== exp_n.deg) begin
            $display("%0t: degenerate expected %0b got %0b", $time, exp_n.deg, got.deg);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_triangle_unit_face_normal_core.sv @@
module tb_triangle_unit_face_normal_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] v [9] = '{default: '0};
  logic out_valid;
  logic signed [15:0] out_nx, out_ny, out_nz;
  logic out_degenerate;
  int fail_count;
  int normals_pending;
  int cycles = 0;
  int idle_pct = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  triangle_unit_face_normal_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ax(v[0]), .in_ay(v[1]), .in_az(v[2]), .in_bx(v[3]), .in_by(v[4]),
    .in_bz(v[5]), .in_cx(v[6]), .in_cy(v[7]), .in_cz(v[8]),
    .out_valid(out_valid), .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate)
  );

  tb_triangle_unit_face_normal_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ax(v[0]), .in_ay(v[1]), .in_az(v[2]), .in_bx(v[3]), .in_by(v[4]),
    .in_bz(v[5]), .in_cx(v[6]), .in_cy(v[7]), .in_cz(v[8]),
    .out_valid(out_valid), .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate), .fail_count(fail_count),
    .normals_pending(normals_pending)
  );

  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_triangle(logic [15:0] t [9]);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    foreach (v[i]) v[i] <= t[i];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [15:0] t [9];
    for (int n = 0; n < count; n++) begin
      foreach (t[i]) t[i] = random_coord();
      case ($urandom_range(0, 9))
        0: begin
          t[3] = t[0]; t[4] = t[1]; t[5] = t[2];
        end
        1: begin
          t[6] = t[3]; t[7] = t[4]; t[8] = t[5];
        end
        2: begin
          t[3] = t[0] + 16'($urandom_range(0, 2)); t[4] = t[1]; t[5] = t[2];
          t[6] = t[0]; t[7] = t[1] + 16'($urandom_range(0, 2)); t[8] = t[2];
        end
        default: ;
      endcase
      send_triangle(t);
    end
  endtask

  initial begin
    logic [15:0] t [9];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (t[i]) t[i] = 16'h0000;
    send_triangle(t);
    t = '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000,
          16'h0000, 16'h4000, 16'h0000};
    send_triangle(t);
    t = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
          16'h4000, 16'h0000, 16'h0000};
    send_triangle(t);
    t = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
          16'h8000, 16'h7fff, 16'h8000};
    send_triangle(t);
    t = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 16'h7fff, 16'h8000};
    send_triangle(t);
    t = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h8000, 16'h8000, 16'h7fff};
    send_triangle(t);
    t = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
          16'h0000, 16'h0001, 16'h0000};
    send_triangle(t);
    t = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
          16'h0002, 16'h0002, 16'h0002};
    send_triangle(t);
    t = '{16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'hffff, 16'h0003,
          16'h0005, 16'h0002, 16'hffff};
    send_triangle(t);
    t = '{16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0,
          16'h3333, 16'hcccc, 16'h7fff};
    send_triangle(t);
    send_random(400);
    start <= 1'b0;
    while (normals_pending != 0) @(posedge clk);
    idle_pct = 88;
    send_random(200);
    idle_pct = 36;
    send_random(450);
    idle_pct = 0;
    send_random(600);
    start <= 1'b0;
    while (normals_pending != 0) @(posedge clk);
    repeat (tufn_pkg::LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
